// ===== rtl/ecfe_pkg.sv =====
// Package with the framing constants, types and CRC helpers of the escaped CRC frame encoder.
`timescale 1ns / 1ps
package ecfe_pkg;

  localparam int MaxResults = 8;
  localparam int IdxW = $clog2(MaxResults);

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] END_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_BYTE   = 8'h7C;
  localparam logic [7:0] ESC_MASK   = 8'h0F;
  localparam logic [7:0] ESC_SET    = 8'h50;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  typedef logic [7:0] line_byte_t;
  typedef line_byte_t [MaxResults-1:0] burst_t;

  function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == ESC_BYTE) || (b == END_BYTE) || (b == START_BYTE);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b & ESC_MASK) | ESC_SET;
  endfunction

endpackage

// ===== rtl/escaped_crc_frame_encoder.sv =====
// Top level of the escaped CRC frame encoder: framing, escaping, CRC and output sequencing.
`timescale 1ns / 1ps
// Each accepted input word is turned into its complete burst of line bytes (start byte,
// escaped data, escaped CRC and end byte as they apply) and held in a pending register; an
// output sequencer then sends the burst at one word per cycle while out_stall is low. A new
// input word is taken whenever the pending register is empty or is handed to the sequencer in
// that cycle, so the output port sets the rate; a burst holds one to eight line bytes, two
// for an escaped data byte inside a frame. An accepted word passes through the pending
// register and then the output burst register before its first line byte appears.
// crc_init is sampled at the start of each frame.
module escaped_crc_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_frame_end
);
  import ecfe_pkg::*;

  logic [15:0] crc_init_r;
  logic [15:0] crc_r, crc_nxt;
  logic        frame_open_r;

  logic        pvalid_r;
  burst_t      pbuf_r, pbuf_nxt;
  logic [IdxW-1:0] plast_r, plast_nxt;
  logic        pend_r;

  logic        evalid_r;
  burst_t      ebuf_r;
  logic [IdxW-1:0] elast_r;
  logic [IdxW-1:0] eidx_r;
  logic        eend_r;

  logic        in_acc;
  logic        out_take;
  logic        at_last;
  logic        load;

  assign out_take = evalid_r && !out_stall;
  assign at_last  = (eidx_r == elast_r);
  assign load     = pvalid_r && (!evalid_r || (out_take && at_last));
  assign in_stall = pvalid_r && !load;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    logic [IdxW:0] n;
    logic [7:0] b;
    crc_nxt  = crc16_upd(frame_open_r ? crc_r : crc_init_r, in_data_byte);
    pbuf_nxt = '0;
    n        = '0;
    if (!frame_open_r) begin
      pbuf_nxt[n[IdxW-1:0]] = START_BYTE;
      n = n + 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      if (k == 0) begin
        b = in_data_byte;
      end else if (k == 1) begin
        b = crc_nxt[15:8];
      end else begin
        b = crc_nxt[7:0];
      end
      if (k == 0 || in_last_byte) begin
        if (needs_esc(b)) begin
          pbuf_nxt[n[IdxW-1:0]] = ESC_BYTE;
          n = n + 1'b1;
          pbuf_nxt[n[IdxW-1:0]] = esc_code(b);
          n = n + 1'b1;
        end else begin
          pbuf_nxt[n[IdxW-1:0]] = b;
          n = n + 1'b1;
        end
      end
    end
    if (in_last_byte) begin
      pbuf_nxt[n[IdxW-1:0]] = END_BYTE;
      n = n + 1'b1;
    end
    plast_nxt = IdxW'(n - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_init_r   <= '0;
      crc_r        <= '0;
      frame_open_r <= 1'b0;
      pvalid_r     <= 1'b0;
      evalid_r     <= 1'b0;
      eidx_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        crc_init_r <= cfg_wr_data;
      end
      if (in_acc) begin
        crc_r        <= crc_nxt;
        frame_open_r <= !in_last_byte;
        pvalid_r     <= 1'b1;
      end else if (load) begin
        pvalid_r <= 1'b0;
      end
      if (load) begin
        evalid_r <= 1'b1;
        eidx_r   <= '0;
      end else if (out_take) begin
        if (at_last) begin
          evalid_r <= 1'b0;
        end else begin
          eidx_r <= eidx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pbuf_r  <= pbuf_nxt;
      plast_r <= plast_nxt;
      pend_r  <= in_last_byte;
    end
    if (load) begin
      ebuf_r  <= pbuf_r;
      elast_r <= plast_r;
      eend_r  <= pend_r;
    end
  end

  assign out_valid     = evalid_r;
  assign out_byte      = ebuf_r[eidx_r];
  assign out_run_last  = at_last;
  assign out_frame_end = at_last && eend_r;

endmodule

// ===== rtl/ecfe_checker.sv =====
// Port-level assertion checker for the escaped CRC frame encoder, with its bind statement.
`timescale 1ns / 1ps
module ecfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_frame_end
);
  import ecfe_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_run_last))
    else $error("Stalled output word changed.");

  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_byte == END_BYTE && out_run_last)
    else $error("Frame end flag on a word that is not the closing end byte.");

  a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte == ESC_BYTE || out_byte == START_BYTE) |-> !out_run_last)
    else $error("Escape or start byte ended a burst.");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("Output valid right after reset.");

endmodule

bind escaped_crc_frame_encoder ecfe_checker u_ecfe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_run_last  (out_run_last),
  .out_frame_end (out_frame_end)
);

// ===== dv/tb_escaped_crc_frame_encoder.sv =====
// Self-checking testbench for the escaped CRC frame encoder with random idling on both sides.
`timescale 1ns / 1ps
module tb_escaped_crc_frame_encoder;
  import ecfe_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 12;
  localparam int RandomWords = 250;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_end;
  } line_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_frame_end;

  line_word_t  line_q[$];
  line_word_t  burst_q[$];
  line_word_t  want;
  logic [15:0] crc_init_m = 16'h0000;
  logic [15:0] crc_run_m = 16'h0000;
  logic        frame_open_m = 1'b0;
  logic        idle_en = 1'b1;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;

  escaped_crc_frame_encoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_run_last(out_run_last),
    .out_frame_end(out_frame_end)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** escaped_crc_frame_encoder: FAILED **");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (!idle_en || r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void add_line(input logic [7:0] b, input logic is_end);
    burst_q.push_back('{line_byte: b, run_last: 1'b0, frame_end: is_end});
  endfunction

  function automatic void add_escaped(input logic [7:0] b);
    if (b == ESC_BYTE || b == END_BYTE || b == START_BYTE) begin
      add_line(ESC_BYTE, 1'b0);
      add_line((b & ESC_MASK) | ESC_SET, 1'b0);
    end else begin
      add_line(b, 1'b0);
    end
  endfunction

  // Expands one accepted payload word into the line bytes the encoder must send for it.
  function automatic void predict_line_bytes(input logic [7:0] b, input logic last);
    line_word_t w;
    burst_q.delete();
    if (!frame_open_m) begin
      add_line(START_BYTE, 1'b0);
      crc_run_m = crc_init_m;
      frame_open_m = 1'b1;
    end
    crc_run_m = crc_step(crc_run_m, b);
    add_escaped(b);
    if (last) begin
      add_escaped(crc_run_m[15:8]);
      add_escaped(crc_run_m[7:0]);
      add_line(END_BYTE, 1'b1);
      frame_open_m = 1'b0;
    end
    for (int i = 0; i < burst_q.size(); i++) begin
      w = burst_q[i];
      w.run_last = (i == burst_q.size() - 1);
      line_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        $error("unexpected word: out_byte=%h", out_byte);
        fail_cnt++;
      end else begin
        want = line_q.pop_front();
        if (out_byte !== want.line_byte) begin
          $error("out_byte: expected %h, got %h", want.line_byte, out_byte);
          fail_cnt++;
        end
        if (out_run_last !== want.run_last) begin
          $error("out_run_last: expected %b, got %b", want.run_last, out_run_last);
          fail_cnt++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("out_frame_end: expected %b, got %b", want.frame_end, out_frame_end);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    predict_line_bytes(b, last);
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_crc_init(input logic [15:0] v);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk) crc_init_m = v;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_payload();
    if ($urandom_range(0, 4) == 0) return 8'(ESC_BYTE + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_reset_init();
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_escaped_payload();
    send_word(ESC_BYTE, 1'b1);
    send_word(END_BYTE, 1'b1);
    send_word(START_BYTE, 1'b0);
    send_word(8'h7B, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hA5, 1'b1);
  endtask

  // Finds two-byte frames whose CRC high byte, and then low byte, must be escaped.
  task automatic test_escaped_crc();
    logic [15:0] c;
    logic [7:0]  sel;
    logic        found;
    for (int part = 0; part < 2; part++) begin
      found = 1'b0;
      for (int b1 = 0; b1 < 256 && !found; b1++) begin
        for (int b2 = 0; b2 < 256 && !found; b2++) begin
          c = crc_step(crc_step(crc_init_m, 8'(b1)), 8'(b2));
          sel = (part == 0) ? c[15:8] : c[7:0];
          if (sel == ESC_BYTE || sel == END_BYTE || sel == START_BYTE) begin
            found = 1'b1;
            send_word(8'(b1), 1'b0);
            send_word(8'(b2), 1'b1);
          end
        end
      end
    end
  endtask

  task automatic test_crc_init_settings();
    write_crc_init(16'hFFFF);
    send_word(8'h31, 1'b1);
    write_crc_init(16'h1D0F);
    send_word(8'h7E, 1'b0);
    write_crc_init(16'h0000);
    send_word(8'h55, 1'b1);
    send_word(8'hC3, 1'b1);
    write_crc_init(16'h8000);
    send_word(8'h01, 1'b1);
  endtask

  task automatic test_random_frames();
    int sent;
    int frame_len;
    sent = 0;
    while (sent < RandomWords) begin
      idle_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: write_crc_init(16'h0000);
          1: write_crc_init(16'hFFFF);
          default: write_crc_init(16'($urandom_range(0, 65535)));
        endcase
      end
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (int i = 0; i < frame_len; i++) begin
        if (i == frame_len / 2 && i > 0 && $urandom_range(0, 7) == 0) begin
          write_crc_init(16'($urandom_range(0, 65535)));
        end
        send_word(rand_payload(), i == frame_len - 1);
        sent++;
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_reset_init();
    test_escaped_payload();
    test_escaped_crc();
    test_crc_init_settings();
    test_random_frames();
    wait_idle();
    if (fail_cnt == 0) begin
      $display("** escaped_crc_frame_encoder: PASSED **");
    end else begin
      $display("** escaped_crc_frame_encoder: FAILED **");
    end
    $finish;
  end

endmodule
